>>> sv/scs_pkg.sv
// Shared types and constants of the syntactic context scanner.
// Depends on nothing; the scanner and the bench import it.
`default_nettype none
package scs_pkg;

   typedef enum logic [1:0] {
      CTX_NONE   = 2'd0,
      CTX_STRING = 2'd1,
      CTX_LINE   = 2'd2,
      CTX_BLOCK  = 2'd3
   } ctx_type;

   typedef enum logic [1:0] {
      PH_NONE   = 2'd0,
      PH_START1 = 2'd1,
      PH_START2 = 2'd2,
      PH_END1   = 2'd3
   } phase_type;

   localparam logic [1:0] CMD_SCAN    = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_RESTORE = 2'd2;

   localparam logic [2:0] CLS_OTHER    = 3'd0;
   localparam logic [2:0] CLS_ESCAPE   = 3'd1;
   localparam logic [2:0] CLS_OPEN     = 3'd2;
   localparam logic [2:0] CLS_CLOSE    = 3'd3;
   localparam logic [2:0] CLS_COMSTART = 3'd4;
   localparam logic [2:0] CLS_COMEND   = 3'd5;
   localparam logic [2:0] CLS_QUOTE    = 3'd6;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_NUL       = 8'h00;

   localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
   localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

   // Scanner state; the packing (context at bit 0) is also the line snapshot.
   typedef struct packed {
      logic [7:0]         last_char;
      logic               escape_pending;
      logic signed [15:0] depth;
      logic [7:0]         string_delim;
      phase_type          block_phase;
      ctx_type            cur_context;
   } scan_state_type;

endpackage
`default_nettype wire

>>> sv/scs_if.sv
// Valid/ready channel interfaces for the scanner's character and result items.
// Depends on nothing.
`default_nettype none
interface scs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] ch;
   logic [2:0] syntax_class;
   logic       comstart_first;
   logic       comstart_second;
   logic       comend_first;
   logic       comend_second;

   modport source (
      output valid, cmd, ch, syntax_class,
      output comstart_first, comstart_second, comend_first, comend_second,
      input  ready
   );
   modport sink (
      input  valid, cmd, ch, syntax_class,
      input  comstart_first, comstart_second, comend_first, comend_second,
      output ready
   );
endinterface

interface scs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         context_res;
   logic signed [15:0] paren_depth;
   logic               opener_done;

   modport source (
      output valid, context_res, paren_depth, opener_done,
      input  ready
   );
   modport sink (
      input  valid, context_res, paren_depth, opener_done,
      output ready
   );
endinterface
`default_nettype wire

>>> sv/syntactic_context_scanner.sv
// Each item passes the input register and then the result register to rsp_ch.
// Throughput: one item per cycle unless rsp_ch stalls the result register.
// Reset: synchronous, active high; clears state, snapshot and both valid flags.
// No clearing pass; the block accepts items in the first cycle after reset.
// Depends on scs_pkg and the channel interfaces in scs_if.
`default_nettype none
module syntactic_context_scanner (
   input wire logic clock,
   input wire logic reset,
   scs_req_if.sink   req_ch,
   scs_rsp_if.source rsp_ch
);
   import scs_pkg::*;

   // Input register stage
   logic       in_valid_ff;
   logic [1:0] cmd_ff;
   logic [7:0] ch_ff;
   logic [2:0] cls_ff;
   logic       cs1_ff, cs2_ff, ce1_ff, ce2_ff;

   // Architectural state
   scan_state_type state_ff, state_in;
   scan_state_type snapshot_ff;
   logic           snap_we;
   logic           opened;

   // Result register
   logic               out_valid_ff;
   ctx_type            rsp_ctx_ff;
   logic signed [15:0] rsp_depth_ff;
   logic               rsp_open_ff;

   logic advance;   // the item in the input register moves to the result register
   logic take;      // a new item is accepted from req_ch

   // The result register frees up when it is empty or being drained.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   // Next-state logic for one item: command decode, class update, then the
   // two-character comment tracker and the final context fixup.
   always_comb begin
      state_in = state_ff;
      opened   = 1'b0;
      snap_we  = 1'b0;
      unique case (cmd_ff)
         CMD_SCAN: begin
            if (state_ff.escape_pending) begin
               // Skip the escaped character; only drop the flag.
               state_in.escape_pending = 1'b0;
            end else begin
               state_in.last_char = ch_ff;
               unique case (cls_ff)
                  CLS_ESCAPE: begin
                     state_in.escape_pending = 1'b1;
                  end
                  CLS_OPEN: begin
                     if (state_in.cur_context == CTX_NONE && state_in.depth != DEPTH_MAX) begin
                        state_in.depth = state_in.depth + 16'sd1;
                     end
                  end
                  CLS_CLOSE: begin
                     if (state_in.cur_context == CTX_NONE && state_in.depth != DEPTH_MIN) begin
                        state_in.depth = state_in.depth - 16'sd1;
                     end
                  end
                  CLS_COMSTART: begin
                     if (state_in.cur_context == CTX_NONE) begin
                        state_in.cur_context = CTX_LINE;
                        state_in.block_phase = PH_NONE;
                     end
                  end
                  CLS_COMEND: begin
                     if (state_in.cur_context == CTX_LINE) begin
                        state_in.cur_context = CTX_NONE;
                     end else if (state_in.cur_context == CTX_BLOCK &&
                                  (state_in.block_phase == PH_START2 ||
                                   state_in.block_phase == PH_END1)) begin
                        state_in.cur_context = CTX_NONE;
                        state_in.block_phase = PH_NONE;
                     end
                  end
                  CLS_QUOTE: begin
                     if (state_in.cur_context == CTX_STRING &&
                         state_in.string_delim == ch_ff) begin
                        state_in.cur_context  = CTX_NONE;
                        state_in.string_delim = CH_NUL;
                     end else if (state_in.cur_context == CTX_NONE) begin
                        state_in.cur_context  = CTX_STRING;
                        state_in.string_delim = ch_ff;
                        state_in.block_phase  = PH_NONE;
                     end
                  end
                  default: begin
                     // other, and the unused class code, change nothing here
                  end
               endcase

               // Two-character opener/closer tracking; first match wins.
               priority if (cs2_ff && state_in.cur_context == CTX_NONE &&
                            state_in.block_phase == PH_START1) begin
                  state_in.block_phase = PH_START2;
                  opened = 1'b1;
               end else if (cs1_ff && state_in.cur_context == CTX_NONE &&
                            (state_in.block_phase == PH_NONE ||
                             state_in.block_phase == PH_START1)) begin
                  state_in.block_phase = PH_START1;
               end else if (ce2_ff && state_in.cur_context == CTX_BLOCK &&
                            state_in.block_phase == PH_END1) begin
                  state_in.cur_context = CTX_NONE;
                  state_in.block_phase = PH_NONE;
               end else if (ce1_ff && state_in.cur_context == CTX_BLOCK &&
                            (state_in.block_phase == PH_START2 ||
                             state_in.block_phase == PH_END1)) begin
                  state_in.block_phase = PH_END1;
               end else if (state_in.block_phase == PH_START1) begin
                  state_in.block_phase = PH_NONE;
               end else if (state_in.block_phase == PH_END1) begin
                  // Closer abandoned: fall back into the comment body.
                  state_in.cur_context = CTX_NONE;
                  state_in.block_phase = PH_START2;
               end

               // Phase decides whether we sit in a block comment.
               if (state_in.block_phase == PH_START2 && state_in.cur_context == CTX_NONE) begin
                  state_in.cur_context = CTX_BLOCK;
               end else if (state_in.block_phase == PH_NONE &&
                            state_in.cur_context == CTX_BLOCK) begin
                  state_in.cur_context = CTX_NONE;
               end

               // Save the state left by a newline as the line-start snapshot.
               snap_we = (ch_ff == CH_NEWLINE);
            end
         end
         CMD_RESTART: begin
            state_in.cur_context    = CTX_NONE;
            state_in.block_phase    = PH_NONE;
            state_in.string_delim   = CH_NUL;
            state_in.depth          = 16'sd0;
            state_in.escape_pending = (ch_ff == CH_BACKSLASH);
            state_in.last_char      = ch_ff;
            snap_we = (ch_ff == CH_NUL) || (ch_ff == CH_NEWLINE);
         end
         CMD_RESTORE: begin
            state_in = snapshot_ff;
         end
         default: begin
            // unused command: hold state
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         snapshot_ff  <= '0;
      end else begin
         // Load the input register whenever it is empty or moving on.
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
            if (snap_we) begin
               snapshot_ff <= state_in;
            end
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= req_ch.cmd;
         ch_ff  <= req_ch.ch;
         cls_ff <= req_ch.syntax_class;
         cs1_ff <= req_ch.comstart_first;
         cs2_ff <= req_ch.comstart_second;
         ce1_ff <= req_ch.comend_first;
         ce2_ff <= req_ch.comend_second;
      end
      if (advance) begin
         rsp_ctx_ff   <= state_in.cur_context;
         rsp_depth_ff <= state_in.depth;
         rsp_open_ff  <= opened;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.context_res = rsp_ctx_ff;
   assign rsp_ch.paren_depth = rsp_depth_ff;
   assign rsp_ch.opener_done = rsp_open_ff;

`ifndef SYNTHESIS
   // A completed opener always lands in a block comment.
   a_opener_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.opener_done) |-> (rsp_ch.context_res == CTX_BLOCK))
      else $error("opener_done without block comment context");

   // State moves only when an item is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("scanner state changed without an item");

   // The snapshot changes only with an item processed.
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(snapshot_ff))
      else $error("line snapshot changed without an item");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for the syntactic context scanner: directed table and
// random source-like text, checked against an in-bench predictor or a typed row's expectation.
// Depends on scs_pkg, the channel interfaces in scs_if and syntactic_context_scanner.
module tb;
   import scs_pkg::*;

   // Codes the package leaves unnamed: the ignored command and the spare class.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] CLS_SPARE  = 3'd7;

   // Comment flag sets, packed as {comstart_first, comstart_second, comend_first, comend_second}.
   localparam logic [3:0] FL_NONE  = 4'b0000;
   localparam logic [3:0] FL_SLASH = 4'b1001;   // opens "/*", closes "*/"
   localparam logic [3:0] FL_STAR  = 4'b0110;
   localparam logic [3:0] FL_ALL   = 4'b1111;

   localparam int RANDOM_ITEMS = 724;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_PCT     = 37;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
      logic [2:0] cls;
      logic [3:0] flags;
   } char_item_type;

   typedef struct packed {
      ctx_type            ctx;
      logic signed [15:0] depth;
      logic               opened;
   } scan_result_type;

   typedef struct {
      char_item_type   item;
      bit              typed;
      scan_result_type want;
   } table_row_type;

   logic clock;
   logic reset;

   scs_req_if req_ch ();
   scs_rsp_if rsp_ch ();

   syntactic_context_scanner u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: live scanner state and the line-start snapshot.
   scan_state_type scan_model;
   scan_state_type line_mark;

   scan_result_type pending_results[$];
   table_row_type   char_table[$];
   int              mismatch_count;
   bit              quiet;          // no idling on either side while set
   bit              hold_off_req;   // ask the receiver for one long stall

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Step the predictor by one accepted item and return the result it implies.
   function automatic scan_result_type advance_scanner(input char_item_type it);
      scan_state_type  s;
      scan_result_type r;
      logic            opened;
      s = scan_model;
      opened = 1'b0;
      case (it.cmd)
         CMD_SCAN: begin
            if (s.escape_pending) begin
               // Skipped character: clear the escape and nothing else.
               s.escape_pending = 1'b0;
            end else begin
               s.last_char = it.ch;
               case (it.cls)
                  CLS_ESCAPE: s.escape_pending = 1'b1;
                  CLS_OPEN: begin
                     if (s.cur_context == CTX_NONE && s.depth != DEPTH_MAX)
                        s.depth = s.depth + 16'sd1;
                  end
                  CLS_CLOSE: begin
                     if (s.cur_context == CTX_NONE && s.depth != DEPTH_MIN)
                        s.depth = s.depth - 16'sd1;
                  end
                  CLS_COMSTART: begin
                     if (s.cur_context == CTX_NONE) begin
                        s.cur_context = CTX_LINE;
                        s.block_phase = PH_NONE;
                     end
                  end
                  CLS_COMEND: begin
                     if (s.cur_context == CTX_LINE) begin
                        s.cur_context = CTX_NONE;
                     end else if (s.cur_context == CTX_BLOCK &&
                                  (s.block_phase == PH_START2 || s.block_phase == PH_END1)) begin
                        s.cur_context = CTX_NONE;
                        s.block_phase = PH_NONE;
                     end
                  end
                  CLS_QUOTE: begin
                     if (s.cur_context == CTX_STRING && s.string_delim == it.ch) begin
                        s.cur_context  = CTX_NONE;
                        s.string_delim = 8'h00;
                     end else if (s.cur_context == CTX_NONE) begin
                        s.cur_context  = CTX_STRING;
                        s.string_delim = it.ch;
                        s.block_phase  = PH_NONE;
                     end
                  end
                  default: ;
               endcase

               // Two-character opener and closer tracking.
               if (it.flags[2] && s.cur_context == CTX_NONE && s.block_phase == PH_START1) begin
                  s.block_phase = PH_START2;
                  opened = 1'b1;
               end else if (it.flags[3] && s.cur_context == CTX_NONE &&
                            (s.block_phase == PH_NONE || s.block_phase == PH_START1)) begin
                  s.block_phase = PH_START1;
               end else if (it.flags[0] && s.cur_context == CTX_BLOCK &&
                            s.block_phase == PH_END1) begin
                  s.cur_context = CTX_NONE;
                  s.block_phase = PH_NONE;
               end else if (it.flags[1] && s.cur_context == CTX_BLOCK &&
                            (s.block_phase == PH_START2 || s.block_phase == PH_END1)) begin
                  s.block_phase = PH_END1;
               end else if (s.block_phase == PH_START1) begin
                  s.block_phase = PH_NONE;
               end else if (s.block_phase == PH_END1) begin
                  // Lone closer: fall back to an open block comment.
                  s.cur_context = CTX_NONE;
                  s.block_phase = PH_START2;
               end

               if (s.block_phase == PH_START2 && s.cur_context == CTX_NONE)
                  s.cur_context = CTX_BLOCK;
               else if (s.block_phase == PH_NONE && s.cur_context == CTX_BLOCK)
                  s.cur_context = CTX_NONE;

               if (it.ch == CH_NEWLINE)
                  line_mark = s;
            end
         end
         CMD_RESTART: begin
            s = '0;
            s.last_char = it.ch;
            s.escape_pending = (it.ch == CH_BACKSLASH);
            if (it.ch == CH_NUL || it.ch == CH_NEWLINE)
               line_mark = s;
         end
         CMD_RESTORE: s = line_mark;
         default: ;   // unused command leaves the state alone
      endcase
      scan_model = s;
      r.ctx    = s.cur_context;
      r.depth  = s.depth;
      r.opened = opened;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void add_row(input logic [1:0] cmd, input logic [7:0] ch,
                                   input logic [2:0] cls, input logic [3:0] flags,
                                   input bit typed, input ctx_type ctx,
                                   input logic signed [15:0] depth, input logic opened);
      table_row_type row;
      row.item       = '{cmd: cmd, ch: ch, cls: cls, flags: flags};
      row.typed      = typed;
      row.want.ctx   = ctx;
      row.want.depth = depth;
      row.want.opened = opened;
      char_table.push_back(row);
   endfunction

   // Offer one item, hold it until accepted, then queue what it should produce.
   // A typed row queues its own expectation; the predictor still advances.
   task automatic send_char(input char_item_type it, input bit typed,
                            input scan_result_type want);
      scan_result_type predicted;
      bit              taken;
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid           <= 1'b1;
      req_ch.cmd             <= it.cmd;
      req_ch.ch              <= it.ch;
      req_ch.syntax_class    <= it.cls;
      req_ch.comstart_first  <= it.flags[3];
      req_ch.comstart_second <= it.flags[2];
      req_ch.comend_first    <= it.flags[1];
      req_ch.comend_second   <= it.flags[0];
      // Sample ready mid-cycle so the accepting edge is seen without a race.
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      predicted = advance_scanner(it);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Build one random item: mostly C-like text, some commands, some raw noise.
   function automatic char_item_type random_char();
      char_item_type it;
      int            roll;
      it   = '{cmd: CMD_SCAN, ch: 8'h00, cls: CLS_OTHER, flags: FL_NONE};
      roll = $urandom_range(99);
      if (roll < 3) begin
         it.cmd = CMD_RESTART;
         case ($urandom_range(3))
            0: it.ch = CH_NUL;
            1: it.ch = CH_NEWLINE;
            2: it.ch = CH_BACKSLASH;
            default: it.ch = 8'($urandom_range(255));
         endcase
         return it;
      end
      if (roll < 7) begin
         it.cmd = CMD_RESTORE;
         it.ch  = 8'($urandom_range(255));
         return it;
      end
      if (roll < 8) begin
         it.cmd   = CMD_UNUSED;
         it.ch    = 8'($urandom_range(255));
         it.cls   = 3'($urandom_range(7));
         it.flags = 4'($urandom_range(15));
         return it;
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
         it.ch = 8'h61 + 8'($urandom_range(25));   // letters
      end else if (roll < 40) begin
         it.ch = 8'h28; it.cls = CLS_OPEN;
      end else if (roll < 50) begin
         it.ch = 8'h29; it.cls = CLS_CLOSE;
      end else if (roll < 56) begin
         it.ch = 8'h22; it.cls = CLS_QUOTE;
      end else if (roll < 60) begin
         it.ch = 8'h27; it.cls = CLS_QUOTE;
      end else if (roll < 64) begin
         it.ch = CH_BACKSLASH; it.cls = CLS_ESCAPE;
      end else if (roll < 72) begin
         it.ch = 8'h2F; it.flags = FL_SLASH;
      end else if (roll < 80) begin
         it.ch = 8'h2A; it.flags = FL_STAR;
      end else if (roll < 84) begin
         it.ch = 8'h23; it.cls = CLS_COMSTART;
      end else if (roll < 93) begin
         it.ch = CH_NEWLINE; it.cls = CLS_COMEND;
      end else begin
         // Noise: any byte, any class, any flags.
         it.ch    = 8'($urandom_range(255));
         it.cls   = 3'($urandom_range(7));
         it.flags = 4'($urandom_range(15));
      end
      return it;
   endfunction

   // Result checker: compare each accepted result with the oldest expectation.
   always @(negedge clock) begin
      scan_result_type got;
      scan_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.ctx    = ctx_type'(rsp_ch.context_res);
         got.depth  = rsp_ch.paren_depth;
         got.opened = rsp_ch.opener_done;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result ctx=%0d depth=%0d opened=%0b",
                                    got.ctx, got.depth, got.opened));
         end else begin
            want = pending_results.pop_front();
            if (got.ctx !== want.ctx)
               flag_mismatch($sformatf("context got %0d want %0d", got.ctx, want.ctx));
            if (got.depth !== want.depth)
               flag_mismatch($sformatf("depth got %0d want %0d", got.depth, want.depth));
            if (got.opened !== want.opened)
               flag_mismatch($sformatf("opener_done got %0b want %0b", got.opened, want.opened));
         end
      end
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_req) begin
            // Hold ready low so the block fills up and stalls its input.
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("syntactic_context_scanner regression: fail");
      $finish;
   end

   initial begin
      scan_result_type none_want;
      req_ch.valid           = 1'b0;
      req_ch.cmd             = CMD_SCAN;
      req_ch.ch              = 8'h00;
      req_ch.syntax_class    = CLS_OTHER;
      req_ch.comstart_first  = 1'b0;
      req_ch.comstart_second = 1'b0;
      req_ch.comend_first    = 1'b0;
      req_ch.comend_second   = 1'b0;
      mismatch_count = 0;
      quiet          = 1'b0;
      hold_off_req   = 1'b0;
      scan_model     = '0;
      line_mark      = '0;
      none_want      = '0;
      reset          = 1'b1;

      // Directed table; typed rows carry their own expectation.
      // Restore before any snapshot gives all zeros.
      add_row(CMD_RESTORE, 8'h00, CLS_OTHER, FL_NONE, 1, CTX_NONE, 16'sd0, 0);
      // Unused command with every field at its top value is ignored.
      add_row(CMD_UNUSED, 8'hFF, CLS_SPARE, FL_ALL, 1, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h28, CLS_OPEN, FL_NONE, 1, CTX_NONE, 16'sd1, 0);
      add_row(CMD_SCAN, 8'h29, CLS_CLOSE, FL_NONE, 1, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h29, CLS_CLOSE, FL_NONE, 1, CTX_NONE, -16'sd1, 0);
      add_row(CMD_SCAN, 8'h22, CLS_QUOTE, FL_NONE, 1, CTX_STRING, -16'sd1, 0);
      // Inside the string: other quote, a paren, an escape and an escaped quote.
      add_row(CMD_SCAN, 8'h27, CLS_QUOTE, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h28, CLS_OPEN, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, CH_BACKSLASH, CLS_ESCAPE, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h22, CLS_QUOTE, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h22, CLS_QUOTE, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      // Block comment: open, lone closer star, then a real close.
      add_row(CMD_SCAN, 8'h2F, CLS_OTHER, FL_SLASH, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h2A, CLS_OTHER, FL_STAR, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h2A, CLS_OTHER, FL_STAR, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h78, CLS_OTHER, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h2A, CLS_OTHER, FL_STAR, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h2F, CLS_OTHER, FL_SLASH, 0, CTX_NONE, 16'sd0, 0);
      // Line comment closed by newline; the newline takes a snapshot.
      add_row(CMD_SCAN, 8'h23, CLS_COMSTART, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, CH_NEWLINE, CLS_COMEND, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      add_row(CMD_RESTART, 8'h61, CLS_OTHER, FL_NONE, 1, CTX_NONE, 16'sd0, 0);
      add_row(CMD_RESTORE, 8'h00, CLS_OTHER, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      // Restart after a backslash: the next character is skipped.
      add_row(CMD_RESTART, CH_BACKSLASH, CLS_OTHER, FL_NONE, 1, CTX_NONE, 16'sd0, 0);
      add_row(CMD_SCAN, 8'h28, CLS_OPEN, FL_NONE, 0, CTX_NONE, 16'sd0, 0);
      // Spare class acts as other; all flags set.
      add_row(CMD_SCAN, 8'hFF, CLS_SPARE, FL_ALL, 0, CTX_NONE, 16'sd0, 0);
      // Restart at a NUL start point also takes a snapshot.
      add_row(CMD_RESTART, CH_NUL, CLS_OTHER, FL_NONE, 1, CTX_NONE, 16'sd0, 0);
      add_row(CMD_RESTORE, 8'h00, CLS_OTHER, FL_NONE, 0, CTX_NONE, 16'sd0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (char_table[i])
         send_char(char_table[i].item, char_table[i].typed, char_table[i].want);

      // Random text, with one long receiver hold-off and one quiet stretch.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_off_req = 1'b1;
         quiet = (n >= 450 && n < 600);
         send_char(random_char(), 0, none_want);
      end
      quiet = 1'b0;
      req_ch.valid <= 1'b0;

      // Drain the expected results, then keep watching for any stray result.
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("syntactic_context_scanner regression: pass");
      end else begin
         $display("syntactic_context_scanner regression: fail");
      end
      $finish;
   end

endmodule

>>> syntactic_context_scanner.f
sv/scs_pkg.sv
sv/scs_if.sv
sv/syntactic_context_scanner.sv
tb/sv/tb.sv
